// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the COBS frame encoder modules.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CFE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFE_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CFE_ASSERT(name, clk, rst_n, prop, msg)
`define CFE_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/cfe_pkg.sv =====
// Shared constants and types of the COBS frame encoder.
// No dependencies; used by the front, command queue, back and top level.
package cfe_pkg;

    localparam int MAX_MESSAGE_BYTES = 32;
    localparam int BYTE_W            = 8;
    localparam int LIMIT_W           = 9;
    localparam int RUN_IDX_W         = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
    localparam int RUN_LEN_W         = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int RAM_AW            = RUN_IDX_W + 1;
    localparam int RAM_DEPTH         = 2 * (2 ** RUN_IDX_W);
    localparam int CMD_DEPTH         = 4;
    localparam int CMD_PTR_W         = $clog2(CMD_DEPTH);

    localparam logic [RUN_LEN_W-1:0] RUN_LEN_MAX       = RUN_LEN_W'(MAX_MESSAGE_BYTES);
    localparam logic [LIMIT_W-1:0]   FRAME_LIMIT_RESET = LIMIT_W'(256);
    localparam logic [LIMIT_W-1:0]   FRAME_POS_RESET   = LIMIT_W'(1);

    typedef enum logic [1:0] {
        TAIL_NONE        = 2'b00,
        TAIL_ERR         = 2'b01,
        TAIL_DELIM       = 2'b10,
        TAIL_CODE1_DELIM = 2'b11
    } t_tail;

    typedef struct packed {
        logic                 flush;
        logic [RUN_LEN_W-1:0] len;
        logic                 bank;
        t_tail                tail;
    } t_flush_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_release;

endpackage

// ===== rtl/core/cobs_frame_encoder.sv =====
// Top level of the COBS frame encoder: front, command queue, run RAM, back.
// Depends on cfe_pkg, cfe_front, cfe_cmd_fifo, cfe_ram and cfe_back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_data_byte, i_end_of_message
//  out     | output    | o_out_valid / i_out_stall  | o_coded_byte, o_frame_end,
//          |           |                            | o_overflow_error, o_burst_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (frame_limit)
//
// An input word is taken while it is not stalled; words that only extend a run cause no output.
// The back takes a command from the queue, then emits one word per cycle while the
// output is not stalled: code byte and run bytes from the run RAM if it flushes a run,
// then any error or delimiter, with a code byte of 1 before the delimiter after a final zero.
// Input stalls while the command queue is full or the run bank it writes is not yet read out.
// Reset is synchronous and clears control state only; the run RAM is not cleared.
module cobs_frame_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cfe_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [cfe_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_end_of_message,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cfe_pkg::BYTE_W-1:0]   o_coded_byte,
    output logic                         o_frame_end,
    output logic                         o_overflow_error,
    output logic                         o_burst_last
);

    logic                        push;
    cfe_pkg::t_flush_cmd         push_cmd;
    logic                        pop;
    cfe_pkg::t_flush_cmd         head_cmd;
    logic                        fifo_full;
    logic                        fifo_empty;
    cfe_pkg::t_bank_release      release_bank;
    logic                        ram_we;
    logic [cfe_pkg::RAM_AW-1:0]  ram_waddr;
    logic [cfe_pkg::BYTE_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [cfe_pkg::RAM_AW-1:0]  ram_raddr;
    logic [cfe_pkg::BYTE_W-1:0]  ram_rdata;

    cfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .i_fifo_full      (fifo_full),
        .i_release        (release_bank),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata)
    );

    cfe_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    cfe_ram #(
        .WIDTH (cfe_pkg::BYTE_W),
        .DEPTH (cfe_pkg::RAM_DEPTH)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_fifo_empty     (fifo_empty),
        .o_pop            (pop),
        .o_release        (release_bank),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_coded_byte     (o_coded_byte),
        .o_frame_end      (o_frame_end),
        .o_overflow_error (o_overflow_error),
        .o_burst_last     (o_burst_last)
    );

endmodule

// ===== rtl/core/cfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cfe_front.sv =====
// Front part: accepts message bytes, tracks run and frame position, writes runs.
// Depends on cfe_pkg and assert_macros.svh; pushes flush commands to the queue.
`include "assert_macros.svh"
module cfe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cfe_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cfe_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_end_of_message,
    output logic                           o_push,
    output cfe_pkg::t_flush_cmd            o_cmd,
    input  logic                           i_fifo_full,
    input  cfe_pkg::t_bank_release         i_release,
    output logic                           o_ram_we,
    output logic [cfe_pkg::RAM_AW-1:0]     o_ram_waddr,
    output logic [cfe_pkg::BYTE_W-1:0]     o_ram_wdata
);

    logic [cfe_pkg::LIMIT_W-1:0]   r_frame_limit;
    logic [cfe_pkg::RUN_LEN_W-1:0] r_run_len, n_run_len;
    logic [cfe_pkg::LIMIT_W-1:0]   r_frame_pos, n_frame_pos;
    logic                          r_dropping, n_dropping;
    logic                          r_wbank, n_wbank;
    logic [1:0]                    r_bank_busy, n_bank_busy;

    logic                          accept;
    logic                          is_zero;
    logic                          err_first;
    logic                          limit_end;
    logic [cfe_pkg::LIMIT_W-1:0]   pos_mid;
    logic [cfe_pkg::RUN_LEN_W-1:0] len_mid;
    cfe_pkg::t_flush_cmd           cmd;
    logic                          push;
    logic                          we;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_fifo_full || r_bank_busy[r_wbank];
    assign accept      = i_in_valid && !o_in_stall;

    assign is_zero   = (i_data_byte == '0);
    assign err_first = (r_frame_pos >= r_frame_limit)
                    || (!is_zero && (r_run_len >= cfe_pkg::RUN_LEN_MAX));
    assign pos_mid   = r_frame_pos + cfe_pkg::LIMIT_W'(1);
    assign len_mid   = is_zero ? '0 : r_run_len + cfe_pkg::RUN_LEN_W'(1);
    assign limit_end = (pos_mid >= r_frame_limit);

    always_comb begin
        n_run_len   = r_run_len;
        n_frame_pos = r_frame_pos;
        n_dropping  = r_dropping;
        n_wbank     = r_wbank;
        n_bank_busy = r_bank_busy;
        push        = 1'b0;
        we          = 1'b0;
        cmd.flush   = 1'b0;
        cmd.len     = '0;
        cmd.bank    = r_wbank;
        cmd.tail    = cfe_pkg::TAIL_NONE;

        if (i_release.valid) begin
            n_bank_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            if (r_dropping) begin
                if (i_end_of_message) begin
                    n_dropping = 1'b0;
                end
            end else if (err_first) begin
                push        = 1'b1;
                cmd.tail    = cfe_pkg::TAIL_ERR;
                n_run_len   = '0;
                n_frame_pos = cfe_pkg::FRAME_POS_RESET;
                n_dropping  = !i_end_of_message;
            end else begin
                if (is_zero) begin
                    cmd.flush = 1'b1;
                    cmd.len   = r_run_len;
                end else begin
                    we = 1'b1;
                end
                if (i_end_of_message) begin
                    push        = 1'b1;
                    n_run_len   = '0;
                    n_frame_pos = cfe_pkg::FRAME_POS_RESET;
                    if (limit_end) begin
                        cmd.tail = cfe_pkg::TAIL_ERR;
                    end else if (is_zero) begin
                        cmd.tail = cfe_pkg::TAIL_CODE1_DELIM;
                    end else begin
                        cmd.flush = 1'b1;
                        cmd.len   = len_mid;
                        cmd.tail  = cfe_pkg::TAIL_DELIM;
                    end
                end else begin
                    push        = cmd.flush;
                    n_run_len   = len_mid;
                    n_frame_pos = pos_mid;
                end
            end
            if (push && cmd.flush && (cmd.len != '0)) begin
                n_wbank              = ~r_wbank;
                n_bank_busy[r_wbank] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= cfe_pkg::FRAME_LIMIT_RESET;
            r_run_len     <= '0;
            r_frame_pos   <= cfe_pkg::FRAME_POS_RESET;
            r_dropping    <= 1'b0;
            r_wbank       <= 1'b0;
            r_bank_busy   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_frame_limit <= i_cfg_data;
            end
            r_run_len   <= n_run_len;
            r_frame_pos <= n_frame_pos;
            r_dropping  <= n_dropping;
            r_wbank     <= n_wbank;
            r_bank_busy <= n_bank_busy;
        end
    end

    assign o_push      = push;
    assign o_cmd       = cmd;
    assign o_ram_we    = we;
    assign o_ram_waddr = {r_wbank, r_run_len[cfe_pkg::RUN_IDX_W-1:0]};
    assign o_ram_wdata = i_data_byte;

    `CFE_ASSERT(a_release_busy, i_clk, i_rst_n, i_release.valid |-> r_bank_busy[i_release.bank], "release of a bank that is not busy")
    `CFE_NEVER(a_run_len_max, i_clk, i_rst_n, r_run_len > cfe_pkg::RUN_LEN_MAX, "run length beyond buffer")

endmodule

// ===== rtl/core/cfe_cmd_fifo.sv =====
// Short command queue between the front and back parts.
// Depends on cfe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cfe_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfe_pkg::t_flush_cmd i_cmd,
    input  logic                i_pop,
    output cfe_pkg::t_flush_cmd o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    cfe_pkg::t_flush_cmd          r_mem [cfe_pkg::CMD_DEPTH];
    logic [cfe_pkg::CMD_PTR_W:0]  r_wr_ptr;
    logic [cfe_pkg::CMD_PTR_W:0]  r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[cfe_pkg::CMD_PTR_W] != r_rd_ptr[cfe_pkg::CMD_PTR_W])
                  && (r_wr_ptr[cfe_pkg::CMD_PTR_W-1:0] == r_rd_ptr[cfe_pkg::CMD_PTR_W-1:0]);
    assign o_cmd   = r_mem[r_rd_ptr[cfe_pkg::CMD_PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[cfe_pkg::CMD_PTR_W-1:0]] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (cfe_pkg::CMD_PTR_W + 1)'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + (cfe_pkg::CMD_PTR_W + 1)'(1);
            end
        end
    end

    `CFE_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `CFE_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> !o_empty, "pop from empty queue")

endmodule

// ===== rtl/core/cfe_back.sv =====
// Back part: runs flush, error and delimiter commands and drives output words.
// Depends on cfe_pkg and assert_macros.svh; reads runs from the run RAM.
`include "assert_macros.svh"
module cfe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cfe_pkg::t_flush_cmd         i_cmd,
    input  logic                        i_fifo_empty,
    output logic                        o_pop,
    output cfe_pkg::t_bank_release      o_release,
    output logic                        o_ram_re,
    output logic [cfe_pkg::RAM_AW-1:0]  o_ram_raddr,
    input  logic [cfe_pkg::BYTE_W-1:0]  i_ram_rdata,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [cfe_pkg::BYTE_W-1:0]  o_coded_byte,
    output logic                        o_frame_end,
    output logic                        o_overflow_error,
    output logic                        o_burst_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CODE  = 6'b000010,
        S_DATA  = 6'b000100,
        S_ERR   = 6'b001000,
        S_CODE1 = 6'b010000,
        S_DELIM = 6'b100000
    } t_back_state;

    function automatic t_back_state tail_state(input cfe_pkg::t_tail tail);
        t_back_state st;
        case (tail)
            cfe_pkg::TAIL_ERR:         st = S_ERR;
            cfe_pkg::TAIL_DELIM:       st = S_DELIM;
            cfe_pkg::TAIL_CODE1_DELIM: st = S_CODE1;
            default:                   st = S_IDLE;
        endcase
        return st;
    endfunction

    t_back_state                   r_state, n_state;
    cfe_pkg::t_flush_cmd           r_cmd, n_cmd;
    logic [cfe_pkg::RUN_IDX_W-1:0] r_idx, n_idx;

    logic                          r_out_valid;
    logic [cfe_pkg::BYTE_W-1:0]    r_coded_byte;
    logic                          r_frame_end;
    logic                          r_err;
    logic                          r_last;

    logic                          out_free;
    logic                          at_end;
    logic                          tail_none;
    logic                          emit;
    logic [cfe_pkg::BYTE_W-1:0]    out_byte;
    logic                          out_fe;
    logic                          out_err;
    logic                          out_last;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign at_end    = ((cfe_pkg::RUN_LEN_W'(r_idx) + cfe_pkg::RUN_LEN_W'(1)) == r_cmd.len);
    assign tail_none = (r_cmd.tail == cfe_pkg::TAIL_NONE);

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_idx          = r_idx;
        o_pop          = 1'b0;
        emit           = 1'b0;
        out_byte       = '0;
        out_fe         = 1'b0;
        out_err        = 1'b0;
        out_last       = 1'b0;
        o_ram_re       = 1'b0;
        o_ram_raddr    = {r_cmd.bank, {cfe_pkg::RUN_IDX_W{1'b0}}};
        o_release.valid = 1'b0;
        o_release.bank  = r_cmd.bank;

        case (r_state)
            S_IDLE: begin
                if (!i_fifo_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_idx = '0;
                    n_state = i_cmd.flush ? S_CODE : tail_state(i_cmd.tail);
                end
            end
            S_CODE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    out_byte = cfe_pkg::BYTE_W'(r_cmd.len) + cfe_pkg::BYTE_W'(1);
                    out_last = (r_cmd.len == '0) && tail_none;
                    if (r_cmd.len != '0) begin
                        o_ram_re = 1'b1;
                        n_idx    = '0;
                        n_state  = S_DATA;
                    end else begin
                        n_state  = tail_state(r_cmd.tail);
                    end
                end
            end
            S_DATA: begin
                if (out_free) begin
                    emit     = 1'b1;
                    out_byte = i_ram_rdata;
                    out_last = at_end && tail_none;
                    if (at_end) begin
                        o_release.valid = 1'b1;
                        n_state         = tail_state(r_cmd.tail);
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = {r_cmd.bank, r_idx + cfe_pkg::RUN_IDX_W'(1)};
                        n_idx       = r_idx + cfe_pkg::RUN_IDX_W'(1);
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    emit     = 1'b1;
                    out_err  = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CODE1: begin
                if (out_free) begin
                    emit     = 1'b1;
                    out_byte = cfe_pkg::BYTE_W'(1);
                    n_state  = S_DELIM;
                end
            end
            S_DELIM: begin
                if (out_free) begin
                    emit     = 1'b1;
                    out_fe   = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        if (out_free) begin
            r_coded_byte <= out_byte;
            r_frame_end  <= out_fe;
            r_err        <= out_err;
            r_last       <= out_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_coded_byte     = r_coded_byte;
    assign o_frame_end      = r_frame_end;
    assign o_overflow_error = r_err;
    assign o_burst_last     = r_last;

    `CFE_ASSERT(a_end_is_last, i_clk, i_rst_n, (r_out_valid && (r_frame_end || r_err)) |-> r_last, "delimiter or error word not marked last")
    `CFE_ASSERT(a_data_in_run, i_clk, i_rst_n, (r_state == S_DATA) |-> (cfe_pkg::RUN_LEN_W'(r_idx) < r_cmd.len), "run index past run length")

endmodule

// ===== tb/tb_cobs_frame_encoder.sv =====
// Self-checking testbench of cobs_frame_encoder: a directed table, then random messages.
// Each byte is encoded by a local model; model or typed words are checked in order.
// Depends on cfe_pkg and the cobs_frame_encoder RTL.
module tb_cobs_frame_encoder;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 60;
    localparam int PHASE_ITEMS   = 14;
    localparam int BURST_MAX     = cfe_pkg::MAX_MESSAGE_BYTES + 8;

    typedef struct packed {
        logic [cfe_pkg::BYTE_W-1:0] code;
        logic                       fe;
        logic                       err;
        logic                       last;
    } t_coded;

    typedef enum logic {
        ROW_LIMIT,
        ROW_BYTES
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [cfe_pkg::LIMIT_W-1:0] value;
        logic [cfe_pkg::BYTE_W-1:0]  stride;
        logic [8:0]                  reps;
        logic                        eom;
        logic [1:0]                  ntyped;
        t_coded                      e0;
        t_coded                      e1;
        t_coded                      e2;
    } t_row;

    localparam t_coded NIL = '0;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [cfe_pkg::LIMIT_W-1:0]   cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [cfe_pkg::BYTE_W-1:0]    in_byte;
    logic                          in_eom;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [cfe_pkg::BYTE_W-1:0]    out_byte;
    logic                          out_fe;
    logic                          out_err;
    logic                          out_last;

    logic [cfe_pkg::BYTE_W-1:0]    run_buf [cfe_pkg::MAX_MESSAGE_BYTES];
    int                            run_len;
    logic [cfe_pkg::LIMIT_W-1:0]   frame_pos;
    logic                          dropping_msg;
    logic [cfe_pkg::LIMIT_W-1:0]   frame_limit;

    t_coded                        burst [BURST_MAX];
    int                            burst_n;
    t_coded                        typed_w [3];
    t_coded                        pending_coded [$];
    t_row                          plan [$];

    t_coded                        got_w;
    t_coded                        want_w;
    int                            errors = 0;
    int                            cycles = 0;
    int                            stall_cnt = 0;
    int                            stall_pick;
    logic                          quiet = 1'b0;
    int                            n_in = 0;
    int                            n_out = 0;
    int                            n_overflow = 0;
    int                            n_limits = 0;
    int                            n_pauses = 0;

    cobs_frame_encoder dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (in_byte),
        .i_end_of_message (in_eom),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_coded_byte     (out_byte),
        .o_frame_end      (out_fe),
        .o_overflow_error (out_err),
        .o_burst_last     (out_last)
    );

    always #2 clk = ~clk;

    function automatic t_coded mk(input logic [cfe_pkg::BYTE_W-1:0] c, input logic fe,
                                  input logic er, input logic last);
        t_coded w;
        w.code = c;
        w.fe   = fe;
        w.err  = er;
        w.last = last;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [cfe_pkg::LIMIT_W-1:0] phase_limit(input int p);
        case (p)
            0: return cfe_pkg::LIMIT_W'(256);
            1: return cfe_pkg::LIMIT_W'(2);
            2: return cfe_pkg::LIMIT_W'(255);
            3: return cfe_pkg::LIMIT_W'(9);
            4: return cfe_pkg::LIMIT_W'(3);
            5: return cfe_pkg::LIMIT_W'(64);
            6: return cfe_pkg::LIMIT_W'(33);
            default: return cfe_pkg::LIMIT_W'($urandom_range(2, 256));
        endcase
    endfunction

    task automatic add_coded(input logic [cfe_pkg::BYTE_W-1:0] c, input logic fe,
                             input logic er);
        burst[burst_n] = mk(c, fe, er, 1'b0);
        burst_n++;
    endtask

    task automatic flush_run();
        add_coded(cfe_pkg::BYTE_W'(run_len + 1), 1'b0, 1'b0);
        for (int i = 0; i < run_len; i++)
            add_coded(run_buf[i], 1'b0, 1'b0);
        run_len = 0;
    endtask

    task automatic raise_overflow(input logic eom);
        add_coded('0, 1'b0, 1'b1);
        run_len      = 0;
        frame_pos    = cfe_pkg::FRAME_POS_RESET;
        dropping_msg = !eom;
    endtask

    task automatic encode_byte(input logic [cfe_pkg::BYTE_W-1:0] b, input logic eom);
        burst_n = 0;
        if (dropping_msg) begin
            if (eom) dropping_msg = 1'b0;
            return;
        end
        if (frame_pos >= frame_limit) begin
            raise_overflow(eom);
        end else if (b == '0) begin
            flush_run();
            frame_pos = frame_pos + 1'b1;
        end else if (run_len >= cfe_pkg::MAX_MESSAGE_BYTES) begin
            raise_overflow(eom);
        end else begin
            run_buf[run_len] = b;
            run_len++;
            frame_pos = frame_pos + 1'b1;
        end
        if (eom && (burst_n == 0 || !burst[burst_n-1].err)) begin
            if (frame_pos >= frame_limit) begin
                raise_overflow(1'b1);
            end else begin
                flush_run();
                add_coded('0, 1'b1, 1'b0);
                frame_pos = cfe_pkg::FRAME_POS_RESET;
            end
        end
        if (burst_n > 0) burst[burst_n-1].last = 1'b1;
    endtask

    task automatic send_word(input logic [cfe_pkg::BYTE_W-1:0] b, input logic eom,
                             input int typed_n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eom   <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        encode_byte(b, eom);
        if (typed_n > 0) begin
            for (int k = 0; k < typed_n; k++) pending_coded.push_back(typed_w[k]);
        end else begin
            for (int k = 0; k < burst_n; k++) pending_coded.push_back(burst[k]);
        end
        n_in++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_coded.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_frame_limit(input logic [cfe_pkg::LIMIT_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        frame_limit = v;
        n_limits++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message();
        int len;
        int zero_pct;
        int r;
        logic [cfe_pkg::BYTE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 10);
        else if (r < 90) len = $urandom_range(11, 31);
        else             len = $urandom_range(32, 40);
        zero_pct = $urandom_range(0, 50);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < zero_pct)     b = '0;
            else if (r > 96)      b = 8'hff;
            else                  b = cfe_pkg::BYTE_W'($urandom_range(1, 255));
            send_word(b, i == len - 1, 0);
        end
    endtask

    task automatic check_field(input string name, input logic [cfe_pkg::BYTE_W-1:0] want,
                               input logic [cfe_pkg::BYTE_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n || quiet) begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 40) begin
                out_stall <= 1'b0;
                stall_cnt <= $urandom_range(0, 12);
            end else if (stall_pick < 92) begin
                out_stall <= 1'b1;
                stall_cnt <= $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                stall_cnt <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_w = mk(out_byte, out_fe, out_err, out_last);
            n_out++;
            if (got_w.err) n_overflow++;
            if (pending_coded.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h fe=%b err=%b last=%b",
                         $time, got_w.code, got_w.fe, got_w.err, got_w.last);
            end else begin
                want_w = pending_coded.pop_front();
                check_field("coded_byte", want_w.code, got_w.code);
                check_field("frame_end", cfe_pkg::BYTE_W'(want_w.fe),
                            cfe_pkg::BYTE_W'(got_w.fe));
                check_field("overflow_error", cfe_pkg::BYTE_W'(want_w.err),
                            cfe_pkg::BYTE_W'(got_w.err));
                check_field("burst_last", cfe_pkg::BYTE_W'(want_w.last),
                            cfe_pkg::BYTE_W'(got_w.last));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row                       row;
        logic [cfe_pkg::BYTE_W-1:0] b;
        int                         phase;
        int                         phase_end;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        in_eom    = 1'b0;
        for (int i = 0; i < cfe_pkg::MAX_MESSAGE_BYTES; i++) run_buf[i] = '0;
        run_len      = 0;
        frame_pos    = cfe_pkg::FRAME_POS_RESET;
        dropping_msg = 1'b0;
        frame_limit  = cfe_pkg::FRAME_LIMIT_RESET;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // kind, value, stride, reps, eom, typed count, typed words
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd1,   1'b1, 2'd3,
                         mk(8'h01, 1'b0, 1'b0, 1'b0), mk(8'h01, 1'b0, 1'b0, 1'b0),
                         mk(8'h00, 1'b1, 1'b0, 1'b1)});
        plan.push_back('{ROW_BYTES, 9'h0ff, 8'd0, 9'd1,   1'b1, 2'd3,
                         mk(8'h02, 1'b0, 1'b0, 1'b0), mk(8'hff, 1'b0, 1'b0, 1'b0),
                         mk(8'h00, 1'b1, 1'b0, 1'b1)});
        plan.push_back('{ROW_BYTES, 9'h011, 8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h001, 8'd0, 9'd1,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd3,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h001, 8'd1, 9'd32,  1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h0e0, 8'd1, 9'd32,  1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h07f, 8'd0, 9'd1,   1'b0, 2'd1,
                         mk(8'h00, 1'b0, 1'b1, 1'b1), NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd3,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h055, 8'd0, 9'd1,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h040, 8'd1, 9'd33,  1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_LIMIT, 9'd2,   8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h0aa, 8'd0, 9'd1,   1'b1, 2'd1,
                         mk(8'h00, 1'b0, 1'b1, 1'b1), NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd1,   1'b1, 2'd2,
                         mk(8'h01, 1'b0, 1'b0, 1'b0), mk(8'h00, 1'b0, 1'b1, 1'b1), NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd2,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_LIMIT, 9'd3,   8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h001, 8'd1, 9'd4,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h0c3, 8'd0, 9'd1,   1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_LIMIT, 9'd48,  8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd47,  1'b1, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h000, 8'd0, 9'd1,   1'b1, 2'd3,
                         mk(8'h01, 1'b0, 1'b0, 1'b0), mk(8'h01, 1'b0, 1'b0, 1'b0),
                         mk(8'h00, 1'b1, 1'b0, 1'b1)});
        plan.push_back('{ROW_LIMIT, 9'd255, 8'd0, 9'd1,   1'b0, 2'd0, NIL, NIL, NIL});
        plan.push_back('{ROW_BYTES, 9'h07e, 8'd0, 9'd1,   1'b1, 2'd0, NIL, NIL, NIL});

        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_LIMIT) begin
                set_frame_limit(row.value);
            end else begin
                typed_w[0] = row.e0;
                typed_w[1] = row.e1;
                typed_w[2] = row.e2;
                for (int i = 0; i < row.reps; i++) begin
                    b = cfe_pkg::BYTE_W'(row.value[cfe_pkg::BYTE_W-1:0] + row.stride * i);
                    send_word(b, row.eom && (i == row.reps - 1),
                              (i == row.reps - 1) ? int'(row.ntyped) : 0);
                end
            end
        end

        phase = 0;
        phase_end = n_in;
        while (n_in - phase_end < RANDOM_ITEMS || phase < 4) begin
            quiet = (phase % 4 == 3);
            set_frame_limit(phase_limit(phase));
            for (int m = n_in; n_in - m < PHASE_ITEMS;) begin
                if (n_pauses == 0 || $urandom_range(0, 7) == 0) begin
                    wait_drained();
                    n_pauses++;
                end
                send_message();
            end
            phase++;
        end
        quiet = 1'b0;

        wait_drained();
        $display("covered %0d input bytes, %0d coded words, %0d overflow results",
                 n_in, n_out, n_overflow);
        $display("over %0d frame limit settings and %0d drain pauses", n_limits, n_pauses);
        if (errors == 0 && pending_coded.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
